/* hdl/lars_pkg.sv */
`default_nettype none

package lars_pkg;

   localparam int MAX_WIDTH = 64;
   localparam int ROW_BITS = 64;
   localparam int WIDTH_BITS = 7;
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 7'd64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_COUNT_BITS = 3;
   localparam logic [3:0] BIRTH_COUNT = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef struct packed {
      logic upper;
      logic middle;
      logic below;
   } cell_link_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] next_cells;
      logic                grid_done;
   } result_type;

   function automatic logic next_state(input logic alive, input logic [3:0] neighbors);
      next_state = (neighbors == BIRTH_COUNT) || (alive && (neighbors == SURVIVE_COUNT));
   endfunction

endpackage

`default_nettype wire

/* hdl/lars_req_if.sv */
`default_nettype none

interface lars_req_if;
   logic                          valid;
   logic                          ready;
   logic [lars_pkg::ROW_BITS-1:0] row_cells;
   logic                          final_row;

   modport source (output valid, output row_cells, output final_row, input ready);
   modport sink (input valid, input row_cells, input final_row, output ready);
endinterface

`default_nettype wire

/* hdl/lars_rsp_if.sv */
`default_nettype none

interface lars_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lars_pkg::ROW_BITS-1:0] next_cells;
   logic                          grid_done;

   modport source (output valid, output next_cells, output grid_done, input ready);
   modport sink (input valid, input next_cells, input grid_done, output ready);
endinterface

`default_nettype wire

/* hdl/life_automaton_row_stepper_top.sv */
// Game of Life (B3/S23) row stepper.
// Rows of a grid arrive on the req channel, one row per transfer, bit k being
// column k; final_row marks the bottom row. Each transfer after the first row
// of a grid yields the next generation of the row above it on the rsp channel.
// The bottom row yields two results, the second with grid_done set; a grid of
// one row yields a single result with grid_done set.
// The csr port sets the grid width; columns at or above it count as dead.
// A row of 64 column cells holds the two previous rows and computes both
// possible results in the cycle of the transfer.
// A result is pushed into the queue when the row that causes it is accepted.
// One row is accepted in every cycle while ready is high; the bottom row's two
// results are made up for by the silent first row of each grid, so with an
// always-ready receiver a steady stream of grids runs at one row per cycle with no gap.
// Results wait in a four-entry queue; ready drops while more than two wait,
// so a stalled receiver holds the queue and back-pressures the sender.
// Reset clears the held rows and the queue and sets the width to 64.
`default_nettype none

module life_automaton_row_stepper_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lars_req_if.sink                           req_channel,
   lars_rsp_if.source                         rsp_channel,
   input  wire logic                          csr_write_en,
   input  wire logic [lars_pkg::WIDTH_BITS-1:0] csr_write_data
);

   logic [lars_pkg::WIDTH_BITS-1:0] width_ff, width_in;
   logic held_ff, held_in;
   logic accept;
   logic has_room;
   logic [lars_pkg::ROW_BITS-1:0] middle_next;
   logic [lars_pkg::ROW_BITS-1:0] below_next;
   lars_pkg::cell_link_type links [lars_pkg::MAX_WIDTH+2];
   lars_pkg::result_type first_result;
   lars_pkg::result_type second_result;
   lars_pkg::result_type out_result;
   logic push_one;
   logic push_two;

   assign links[0] = '0;
   assign links[lars_pkg::MAX_WIDTH+1] = '0;

   for (genvar c = 0; c < lars_pkg::MAX_WIDTH; c++) begin : g_cells
      lars_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (lars_pkg::WIDTH_BITS'(c) < width_ff),
         .load        (accept),
         .clear       (req_channel.final_row),
         .row_bit     (req_channel.row_cells[c]),
         .left_link   (links[c]),
         .right_link  (links[c+2]),
         .own_link    (links[c+1]),
         .next_middle (middle_next[c]),
         .next_below  (below_next[c])
      );
   end

   for (genvar c = lars_pkg::MAX_WIDTH; c < lars_pkg::ROW_BITS; c++) begin : g_pad
      assign middle_next[c] = 1'b0;
      assign below_next[c] = 1'b0;
   end

   always_comb begin
      accept = req_channel.valid && has_room;
      push_one = 1'b0;
      push_two = 1'b0;
      first_result.next_cells = middle_next;
      first_result.grid_done = 1'b0;
      second_result.next_cells = below_next;
      second_result.grid_done = 1'b1;
      if (accept) begin
         if (held_ff) begin
            push_one = !req_channel.final_row;
            push_two = req_channel.final_row;
         end else if (req_channel.final_row) begin
            push_one = 1'b1;
            first_result = second_result;
         end
      end
      held_in = held_ff;
      if (accept) begin
         held_in = !req_channel.final_row;
      end
      width_in = csr_write_en ? csr_write_data : width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= lars_pkg::WIDTH_RESET;
         held_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         held_ff <= held_in;
      end
   end

   lars_result_queue u_queue (
      .clock         (clock),
      .reset         (reset),
      .push_one      (push_one),
      .push_two      (push_two),
      .first_result  (first_result),
      .second_result (second_result),
      .has_room      (has_room),
      .out_valid     (rsp_channel.valid),
      .out_ready     (rsp_channel.ready),
      .out_result    (out_result)
   );

   assign req_channel.ready = has_room;
   assign rsp_channel.next_cells = out_result.next_cells;
   assign rsp_channel.grid_done = out_result.grid_done;

endmodule

`default_nettype wire

/* hdl/lars_cell.sv */
`default_nettype none

module lars_cell (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire logic                    load,
   input  wire logic                    clear,
   input  wire logic                    row_bit,
   input  wire lars_pkg::cell_link_type left_link,
   input  wire lars_pkg::cell_link_type right_link,
   output lars_pkg::cell_link_type      own_link,
   output logic                         next_middle,
   output logic                         next_below
);

   logic upper_ff, upper_in;
   logic middle_ff, middle_in;
   logic [3:0] middle_sum;
   logic [3:0] below_sum;

   always_comb begin
      own_link.upper = upper_ff & enable;
      own_link.middle = middle_ff & enable;
      own_link.below = row_bit & enable;

      middle_sum = 4'(left_link.upper) + 4'(own_link.upper) + 4'(right_link.upper)
                 + 4'(left_link.middle) + 4'(right_link.middle)
                 + 4'(left_link.below) + 4'(own_link.below) + 4'(right_link.below);
      below_sum = 4'(left_link.middle) + 4'(own_link.middle) + 4'(right_link.middle)
                + 4'(left_link.below) + 4'(right_link.below);

      next_middle = lars_pkg::next_state(own_link.middle, middle_sum) & enable;
      next_below = lars_pkg::next_state(own_link.below, below_sum) & enable;

      upper_in = upper_ff;
      middle_in = middle_ff;
      if (load) begin
         if (clear) begin
            upper_in = 1'b0;
            middle_in = 1'b0;
         end else begin
            upper_in = middle_ff;
            middle_in = own_link.below;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         upper_ff <= upper_in;
         middle_ff <= middle_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/lars_result_queue.sv */
`default_nettype none

module lars_result_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_one,
   input  wire logic                 push_two,
   input  wire lars_pkg::result_type first_result,
   input  wire lars_pkg::result_type second_result,
   output logic                      has_room,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output lars_pkg::result_type      out_result
);

   lars_pkg::result_type entries_ff [lars_pkg::QUEUE_DEPTH];
   logic [lars_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lars_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lars_pkg::QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [lars_pkg::QUEUE_PTR_BITS-1:0] wr_next_ptr;
   logic pop;
   logic [lars_pkg::QUEUE_COUNT_BITS-1:0] push_count;

   always_comb begin
      has_room = count_ff <= lars_pkg::QUEUE_COUNT_BITS'(lars_pkg::QUEUE_DEPTH - 2);
      out_valid = count_ff != '0;
      out_result = entries_ff[rd_ptr_ff];
      pop = out_valid && out_ready;
      wr_next_ptr = wr_ptr_ff + lars_pkg::QUEUE_PTR_BITS'(1);
      push_count = push_two ? lars_pkg::QUEUE_COUNT_BITS'(2) :
                   (push_one ? lars_pkg::QUEUE_COUNT_BITS'(1) : '0);
      wr_ptr_in = wr_ptr_ff + push_count[lars_pkg::QUEUE_PTR_BITS-1:0];
      rd_ptr_in = pop ? rd_ptr_ff + lars_pkg::QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in = count_ff + push_count - lars_pkg::QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_one || push_two) begin
         entries_ff[wr_ptr_ff] <= first_result;
      end
      if (push_two) begin
         entries_ff[wr_next_ptr] <= second_result;
      end
   end

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int ITEM_TARGET = 1900;
   localparam int PHASE_ROWS = 150;
   localparam int IDLE_LIMIT = 2000;

   typedef struct {
      logic [lars_pkg::ROW_BITS-1:0] cells;
      logic                          bottom;
   } grid_row_type;

   typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_PERIODIC} rx_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [lars_pkg::WIDTH_BITS-1:0] csr_write_data;

   lars_req_if req_bus ();
   lars_rsp_if rsp_bus ();

   life_automaton_row_stepper_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_channel    (req_bus),
      .rsp_channel    (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   grid_row_type         pending_rows[$];
   lars_pkg::result_type expected_generations[$];

   logic [lars_pkg::WIDTH_BITS-1:0] grid_width_now = lars_pkg::WIDTH_RESET;
   logic [lars_pkg::ROW_BITS-1:0]   upper_row = '0;
   logic [lars_pkg::ROW_BITS-1:0]   middle_row = '0;
   int                              rows_held = 0;
   int                              rows_queued = 0;
   int                              mismatches = 0;
   int                              burst_left = 0;
   int                              gap_left = 0;
   int                              mode_left = 0;
   int                              idle_cycles = 0;
   rx_mode_type                     rx_mode = RX_FREE;

   function automatic logic [lars_pkg::ROW_BITS-1:0] live_mask(
         input logic [lars_pkg::WIDTH_BITS-1:0] w);
      if (w >= lars_pkg::MAX_WIDTH) begin
         return '1;
      end
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic int cell_at(input logic [lars_pkg::ROW_BITS-1:0] row, input int col);
      if (col < 0 || col >= lars_pkg::ROW_BITS) begin
         return 0;
      end
      return int'(row[col]);
   endfunction

   function automatic logic [lars_pkg::ROW_BITS-1:0] next_generation(
         input logic [lars_pkg::ROW_BITS-1:0]   above,
         input logic [lars_pkg::ROW_BITS-1:0]   here,
         input logic [lars_pkg::ROW_BITS-1:0]   below,
         input logic [lars_pkg::WIDTH_BITS-1:0] w);
      logic [lars_pkg::ROW_BITS-1:0] m;
      logic [lars_pkg::ROW_BITS-1:0] a;
      logic [lars_pkg::ROW_BITS-1:0] h;
      logic [lars_pkg::ROW_BITS-1:0] b;
      logic [lars_pkg::ROW_BITS-1:0] nxt;
      int                            n;
      m = live_mask(w);
      a = above & m;
      h = here & m;
      b = below & m;
      nxt = '0;
      for (int c = 0; c < lars_pkg::ROW_BITS; c++) begin
         n = cell_at(a, c - 1) + cell_at(a, c) + cell_at(a, c + 1)
           + cell_at(h, c - 1) + cell_at(h, c + 1)
           + cell_at(b, c - 1) + cell_at(b, c) + cell_at(b, c + 1);
         nxt[c] = (n == int'(lars_pkg::BIRTH_COUNT))
                  || (h[c] && n == int'(lars_pkg::SURVIVE_COUNT));
      end
      return nxt & m;
   endfunction

   task automatic predict_generations(input logic [lars_pkg::ROW_BITS-1:0] row_in,
                                      input logic bottom);
      logic [lars_pkg::ROW_BITS-1:0] row;
      lars_pkg::result_type          r;
      row = row_in & live_mask(grid_width_now);
      if (rows_held == 0) begin
         if (bottom) begin
            r.next_cells = next_generation('0, row, '0, grid_width_now);
            r.grid_done = 1'b1;
            expected_generations.push_back(r);
         end else begin
            upper_row = '0;
            middle_row = row;
            rows_held = 1;
         end
      end else begin
         r.next_cells = next_generation(upper_row, middle_row, row, grid_width_now);
         r.grid_done = 1'b0;
         expected_generations.push_back(r);
         if (bottom) begin
            r.next_cells = next_generation(middle_row, row, '0, grid_width_now);
            r.grid_done = 1'b1;
            expected_generations.push_back(r);
            upper_row = '0;
            middle_row = '0;
            rows_held = 0;
         end else begin
            upper_row = middle_row;
            middle_row = row;
            rows_held = 2;
         end
      end
   endtask

   task automatic queue_row(input logic [lars_pkg::ROW_BITS-1:0] cells, input logic bottom);
      grid_row_type item;
      item.cells = cells;
      item.bottom = bottom;
      pending_rows.push_back(item);
      rows_queued++;
   endtask

   function automatic logic [lars_pkg::ROW_BITS-1:0] random_row();
      logic [lars_pkg::ROW_BITS-1:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: return v;
         1: return v & {$urandom, $urandom};
         2: return v & {$urandom, $urandom} & {$urandom, $urandom};
         3: return ($urandom_range(0, 1) == 1) ? '1 : '0;
         4: return (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
         default: return 64'h7 << $urandom_range(0, 63);
      endcase
   endfunction

   task automatic wait_for_drain();
      while (pending_rows.size() != 0 || expected_generations.size() != 0 || req_bus.valid) begin
         @(negedge clock);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.row_cells <= '0;
         req_bus.final_row <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_generations(req_bus.row_cells, req_bus.final_row);
            pending_rows.delete(0);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_rows.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.row_cells <= pending_rows[0].cells;
               req_bus.final_row <= pending_rows[0].bottom;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each transfer and stalls in a pattern that changes mode.
   always @(posedge clock) begin : result_checker
      lars_pkg::result_type due;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_generations.size() == 0) begin
               $display("%0t: unexpected result next_cells %h grid_done %b", $time,
                        rsp_bus.next_cells, rsp_bus.grid_done);
               mismatches++;
            end else begin
               due = expected_generations.pop_front();
               if (rsp_bus.next_cells !== due.next_cells) begin
                  $display("%0t: next_cells expected %h actual %h", $time,
                           due.next_cells, rsp_bus.next_cells);
                  mismatches++;
               end
               if (rsp_bus.grid_done !== due.grid_done) begin
                  $display("%0t: grid_done expected %b actual %b", $time,
                           due.grid_done, rsp_bus.grid_done);
                  mismatches++;
               end
            end
         end
         if (mode_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 160);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_FREE: rsp_bus.ready <= 1'b1;
            RX_COIN: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            RX_SLOW: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_bus.ready <= ((mode_left % 8) >= 5);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("life_automaton_row_stepper_top test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [lars_pkg::WIDTH_BITS-1:0] fixed_widths[9];
      logic [lars_pkg::WIDTH_BITS-1:0] w;
      int                              phase;
      int                              phase_end;
      int                              rows;
      fixed_widths = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd3, 7'd63, 7'd65, 7'd64, 7'd32};
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed grids at the reset width: single-row grids, edge columns,
      // oscillators and full or empty rows.
      @(negedge clock);
      queue_row('1, 1'b1);
      queue_row('0, 1'b1);
      queue_row(64'h8000_0000_0000_0001, 1'b0);
      queue_row(64'h8000_0000_0000_0001, 1'b0);
      queue_row(64'h8000_0000_0000_0001, 1'b1);
      queue_row('0, 1'b0);
      queue_row(64'h7 << 30, 1'b0);
      queue_row('0, 1'b1);
      queue_row('1, 1'b0);
      queue_row('1, 1'b1);
      queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_row(64'h5555_5555_5555_5555, 1'b0);
      queue_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      queue_row(64'h5555_5555_5555_5555, 1'b1);
      queue_row(64'hC000_0000_0000_0003, 1'b0);
      queue_row(64'hC000_0000_0000_0003, 1'b0);
      queue_row('0, 1'b1);

      phase = 0;
      while (rows_queued < ITEM_TARGET) begin
         wait_for_drain();
         repeat (4) @(posedge clock);
         if (phase < 9) begin
            w = fixed_widths[phase];
         end else if ($urandom_range(0, 3) != 0) begin
            w = lars_pkg::WIDTH_BITS'($urandom_range(1, lars_pkg::MAX_WIDTH));
         end else begin
            w = lars_pkg::WIDTH_BITS'($urandom_range(0, 127));
         end
         @(posedge clock);
         csr_write_en <= 1'b1;
         csr_write_data <= w;
         grid_width_now <= w;
         @(posedge clock);
         csr_write_en <= 1'b0;
         @(negedge clock);
         phase_end = rows_queued + PHASE_ROWS;
         if (phase_end > ITEM_TARGET) begin
            phase_end = ITEM_TARGET;
         end
         while (rows_queued < phase_end) begin
            rows = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
            for (int k = 1; k <= rows; k++) begin
               queue_row(random_row(), k == rows);
            end
         end
         // Sometimes a grid is left open so that the width changes mid-grid.
         if (rows_queued < ITEM_TARGET && $urandom_range(0, 3) == 0) begin
            rows = $urandom_range(1, 2);
            for (int k = 0; k < rows; k++) begin
               queue_row(random_row(), 1'b0);
            end
         end
         phase++;
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_generations.size() == 0) begin
         $display("life_automaton_row_stepper_top test passed");
      end else begin
         $display("life_automaton_row_stepper_top test failed");
      end
      $finish;
   end

endmodule
